// File: hw/rtl/rdcr_pkg.sv
package rdcr_pkg;

	// default fraction width of fractions and results
	localparam int FRAC_BITS_DEF = 16;

	// field widths fixed by the interface
	localparam int CFG_W = 17;
	localparam int OUT_W = 32;

	// register stages between the cube roots and the reciprocal rows
	localparam int PREP_STAGES = 6;

	// register reset values, Q1.16
	localparam logic [CFG_W-1:0] FRICTION_RST = 17'd32768;
	localparam logic [CFG_W-1:0] PACKING_RST  = 17'd41288;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRICTION = 1'b0,
		REG_PACKING  = 1'b1
	} cfg_reg_t;

	// status handed from the prep stages to the reciprocal rows
	typedef struct packed {
		logic val_big;
		logic slope_zero;
	} prep_flags_t;

endpackage

// File: hw/rtl/rdcr_div_cell.sv
module rdcr_div_cell #(
	parameter int REM_W  = 17,
	parameter int QUO_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [REM_W-1:0]  rem_i,
	input  logic [REM_W-1:0]  dvs_i,
	input  logic [QUO_W-1:0]  quo_i,
	input  logic              bit_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic [REM_W-1:0]  rem_q,
	output logic [QUO_W-1:0]  quo_q,
	output logic [SIDE_W-1:0] side_q
);

	logic [REM_W:0] cur;
	logic [REM_W:0] dif;
	logic           ge;

	// one restoring division step: bring down a bit, try the subtract
	always_comb begin
		cur = {rem_i, bit_i};
		dif = cur - {1'b0, dvs_i};
		ge  = (cur >= {1'b0, dvs_i});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? dif[REM_W-1:0] : cur[REM_W-1:0];
			quo_q  <= {quo_i[QUO_W-2:0], ge};
			side_q <= side_i;
		end
	end

endmodule

// File: hw/rtl/rdcr_root_cell.sv
module rdcr_root_cell #(
	parameter int ROOT_W = 22,
	parameter int STEP   = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [3*ROOT_W-1:0]   rad_i,
	input  logic [2*ROOT_W+4:0]   r_i,
	input  logic [ROOT_W-1:0]     y_i,
	input  logic [2*ROOT_W-1:0]   y2_i,
	output logic [3*ROOT_W-1:0]   rad_q,
	output logic [2*ROOT_W+4:0]   r_q,
	output logic [ROOT_W-1:0]     y_q,
	output logic [2*ROOT_W-1:0]   y2_q
);

	localparam int RES_W = 2*ROOT_W + 5;
	localparam int SQ_W  = 2*ROOT_W;
	localparam int SH    = 3*(ROOT_W - 1 - STEP);

	logic [RES_W-1:0] rs;
	logic [RES_W-1:0] bb;
	logic             ge;

	// next three radicand bits; trial term 12*y^2 + 6*y + 1
	always_comb begin
		rs = {r_i[RES_W-4:0], rad_i[SH +: 3]};
		bb = RES_W'({y2_i, 3'b000}) + RES_W'({y2_i, 2'b00})
			+ RES_W'({y_i, 2'b00}) + RES_W'({y_i, 1'b0}) + RES_W'(1);
		ge = (rs >= bb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= rad_i;
			r_q   <= ge ? (rs - bb) : rs;
			y_q   <= {y_i[ROOT_W-2:0], ge};
			y2_q  <= ge ? ({y2_i[SQ_W-3:0], 2'b00} + SQ_W'({y_i, 2'b00}) + SQ_W'(1))
				: {y2_i[SQ_W-3:0], 2'b00};
		end
	end

endmodule

// File: hw/rtl/rdcr_prep.sv
module rdcr_prep #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [FRAC_BITS+5:0]            a_i,
	input  logic [FRAC_BITS+5:0]            b_i,
	input  logic [rdcr_pkg::CFG_W-1:0]      p_i,
	output logic [FRAC_BITS:0]              vdiv_s6,
	output logic [2*FRAC_BITS+rdcr_pkg::CFG_W+25:0] sdiv_s6,
	output rdcr_pkg::prep_flags_t           flags_s6
);

	import rdcr_pkg::*;

	localparam int ROOT_W = FRAC_BITS + 6;
	localparam int SQ_W   = 2*ROOT_W;
	localparam int DW     = SQ_W - FRAC_BITS;
	localparam int DSQ_W  = 2*DW;
	localparam int P3_W   = CFG_W + 2;
	localparam int P_W    = DW + P3_W;
	localparam int DDW    = 2*DW + P3_W;
	localparam int VW     = FRAC_BITS + 1;

	logic [P3_W-1:0]   p3;
	logic [SQ_W-1:0]   shf;
	logic [SQ_W-1:0]   dif;

	logic [ROOT_W-1:0] a_s1, a_s2, a_s3, a_s4, a_s5;
	logic [ROOT_W-1:0] b_s1;
	logic [SQ_W-1:0]   sq_s1;
	logic [DW-1:0]     dq_s2;
	logic              dqz_s2, dqz_s3, dqz_s4, dqz_s5;
	logic [DSQ_W-1:0]  dsq_s3;
	logic [P_W-1:0]    lo_s4, lo_s5;
	logic [DW-1:0]     hi_s4;
	logic [P_W-1:0]    hip_s5;

	// three times the packing limit
	always_comb begin
		p3  = P3_W'(p_i) + (P3_W'(p_i) << 1);
		shf = SQ_W'({b_s1, {FRAC_BITS{1'b0}}});
		dif = (shf >= sq_s1) ? (shf - sq_s1) : (sq_s1 - shf);
	end

	// b squared, then |b - b^2|, then its square times 3p in two halves
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_i;
			b_s1   <= b_i;
			sq_s1  <= SQ_W'(b_i) * SQ_W'(b_i);

			a_s2   <= a_s1;
			dq_s2  <= dif[SQ_W-1:FRAC_BITS];
			dqz_s2 <= (dif[SQ_W-1:FRAC_BITS] == '0);

			a_s3   <= a_s2;
			dqz_s3 <= dqz_s2;
			dsq_s3 <= DSQ_W'(dq_s2) * DSQ_W'(dq_s2);

			a_s4   <= a_s3;
			dqz_s4 <= dqz_s3;
			lo_s4  <= P_W'(dsq_s3[DW-1:0]) * P_W'(p3);
			hi_s4  <= dsq_s3[DSQ_W-1:DW];

			a_s5   <= a_s4;
			dqz_s5 <= dqz_s4;
			lo_s5  <= lo_s4;
			hip_s5 <= P_W'(hi_s4) * P_W'(p3);

			sdiv_s6             <= (DDW'(hip_s5) << DW) + DDW'(lo_s5);
			vdiv_s6             <= (VW'(1) << FRAC_BITS) - a_s5[FRAC_BITS:0];
			flags_s6.val_big    <= |a_s5[ROOT_W-1:FRAC_BITS];
			flags_s6.slope_zero <= dqz_s5;
		end
	end

endmodule

// File: hw/rtl/radial_distribution_cube_root.sv
// Radial distribution function g0 = 1/(1 - cbrt(min(alpha,fl)/p)) and its
// slope, one cell value per clock while the output is not stalled. Every
// item passes through a row of 17+3*FRAC_BITS restoring-division cells
// that divides the clamped fraction by the packing limit, a row of
// FRAC_BITS+6 cube-root digit cells, six prep stages and a row of 32
// reciprocal division cells, then the output register. A stall on the
// output freezes the whole row, so the input is stalled only while a
// finished result waits to be taken.
// Configuration writes are applied at once and must be made while the
// pipeline is empty. Results saturate to all ones with saturated set.
module radial_distribution_cube_root #(
	parameter int FRAC_BITS = rdcr_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_idx,
	input  logic [rdcr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rdcr_pkg::CFG_W-1:0]   alpha,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rdcr_pkg::OUT_W-1:0]   radial_value,
	output logic [rdcr_pkg::OUT_W-1:0]   radial_slope,
	output logic                         saturated
);

	import rdcr_pkg::*;

	localparam int QW     = CFG_W + 3*FRAC_BITS;
	localparam int ROOT_W = FRAC_BITS + 6;
	localparam int RAD_W  = 3*ROOT_W;
	localparam int RES_W  = 2*ROOT_W + 5;
	localparam int SQ_W   = 2*ROOT_W;
	localparam int VW     = FRAC_BITS + 1;
	localparam int DDW    = 2*FRAC_BITS + CFG_W + 26;
	localparam int L      = QW + ROOT_W + PREP_STAGES + OUT_W + 1;

	localparam logic [CFG_W-1:0] EPS = CFG_W'(((1 << FRAC_BITS) + 500) / 1000);
	localparam logic [VW-1:0] V_REM0 =
		(2*FRAC_BITS >= OUT_W) ? (VW'(1) << (2*FRAC_BITS - OUT_W)) : '0;
	localparam logic [OUT_W-1:0] V_NUM_LO =
		(2*FRAC_BITS < OUT_W) ? (OUT_W'(1) << (2*FRAC_BITS)) : '0;
	localparam logic [DDW-1:0] S_REM0 =
		(4*FRAC_BITS >= OUT_W) ? (DDW'(1) << (4*FRAC_BITS - OUT_W)) : '0;
	localparam logic [OUT_W-1:0] S_NUM_LO =
		(4*FRAC_BITS < OUT_W) ? (OUT_W'(1) << (4*FRAC_BITS)) : '0;

	logic             en;
	logic [L-1:0]     vld_q;
	logic [CFG_W-1:0] fl_q;
	logic [CFG_W-1:0] pk_q;
	logic [CFG_W-1:0] c_v;
	logic [CFG_W-1:0] c_lo;
	logic [CFG_W-1:0] c_s;

	logic [CFG_W-1:0] v_rem  [0:QW];
	logic [QW-1:0]    v_quo  [0:QW];
	logic [CFG_W-1:0] v_side [0:QW];
	logic [CFG_W-1:0] s_rem  [0:QW];
	logic [QW-1:0]    s_quo  [0:QW];
	logic [CFG_W-1:0] s_side [0:QW];

	logic [RAD_W-1:0]  v_rad [0:ROOT_W];
	logic [RES_W-1:0]  v_r   [0:ROOT_W];
	logic [ROOT_W-1:0] v_y   [0:ROOT_W];
	logic [SQ_W-1:0]   v_y2  [0:ROOT_W];
	logic [RAD_W-1:0]  s_rad [0:ROOT_W];
	logic [RES_W-1:0]  s_r   [0:ROOT_W];
	logic [ROOT_W-1:0] s_y   [0:ROOT_W];
	logic [SQ_W-1:0]   s_y2  [0:ROOT_W];

	logic [VW-1:0]  vdiv_s6;
	logic [DDW-1:0] sdiv_s6;
	prep_flags_t    flags_s6;

	logic [VW-1:0]    vr_rem  [0:OUT_W];
	logic [OUT_W-1:0] vr_quo  [0:OUT_W];
	logic [VW:0]      vr_side [0:OUT_W];
	logic [DDW-1:0]   sr_rem  [0:OUT_W];
	logic [OUT_W-1:0] sr_quo  [0:OUT_W];
	logic [DDW:0]     sr_side [0:OUT_W];

	logic             vbad;
	logic             sbad;
	logic [OUT_W-1:0] value_q;
	logic [OUT_W-1:0] slope_q;
	logic             sat_q;

	// whole row advances unless a result waits on a stalled output
	assign en        = ~(vld_q[L-1] & out_stall);
	assign in_stall  = ~en;
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= FRICTION_RST;
			pk_q <= PACKING_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_FRICTION: fl_q <= cfg_data;
				REG_PACKING:  pk_q <= cfg_data;
			endcase
		end
	end

	// clamp the fraction for the value and for the slope
	always_comb begin
		c_v  = (alpha < fl_q) ? alpha : fl_q;
		c_lo = (alpha > EPS) ? alpha : EPS;
		c_s  = (c_lo > fl_q) ? fl_q : c_lo;
	end

	// divide clamped fraction, shifted by 3F, by the packing limit
	assign v_rem[0]  = '0;
	assign v_quo[0]  = '0;
	assign v_side[0] = c_v;
	assign s_rem[0]  = '0;
	assign s_quo[0]  = '0;
	assign s_side[0] = c_s;

	for (genvar i = 0; i < QW; i++) begin : g_pdiv
		logic v_bit;
		logic s_bit;
		if (i < CFG_W) begin : g_data
			assign v_bit = v_side[i][CFG_W-1-i];
			assign s_bit = s_side[i][CFG_W-1-i];
		end else begin : g_zero
			assign v_bit = 1'b0;
			assign s_bit = 1'b0;
		end
		rdcr_div_cell #(.REM_W(CFG_W), .QUO_W(QW), .SIDE_W(CFG_W)) u_vcell (
			.clk(clk), .en(en),
			.rem_i(v_rem[i]), .dvs_i(pk_q), .quo_i(v_quo[i]), .bit_i(v_bit),
			.side_i(v_side[i]),
			.rem_q(v_rem[i+1]), .quo_q(v_quo[i+1]), .side_q(v_side[i+1])
		);
		rdcr_div_cell #(.REM_W(CFG_W), .QUO_W(QW), .SIDE_W(CFG_W)) u_scell (
			.clk(clk), .en(en),
			.rem_i(s_rem[i]), .dvs_i(pk_q), .quo_i(s_quo[i]), .bit_i(s_bit),
			.side_i(s_side[i]),
			.rem_q(s_rem[i+1]), .quo_q(s_quo[i+1]), .side_q(s_side[i+1])
		);
	end

	// integer cube root of each quotient, one digit per cell
	assign v_rad[0] = RAD_W'(v_quo[QW]);
	assign v_r[0]   = '0;
	assign v_y[0]   = '0;
	assign v_y2[0]  = '0;
	assign s_rad[0] = RAD_W'(s_quo[QW]);
	assign s_r[0]   = '0;
	assign s_y[0]   = '0;
	assign s_y2[0]  = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		rdcr_root_cell #(.ROOT_W(ROOT_W), .STEP(j)) u_vroot (
			.clk(clk), .en(en),
			.rad_i(v_rad[j]), .r_i(v_r[j]), .y_i(v_y[j]), .y2_i(v_y2[j]),
			.rad_q(v_rad[j+1]), .r_q(v_r[j+1]), .y_q(v_y[j+1]), .y2_q(v_y2[j+1])
		);
		rdcr_root_cell #(.ROOT_W(ROOT_W), .STEP(j)) u_sroot (
			.clk(clk), .en(en),
			.rad_i(s_rad[j]), .r_i(s_r[j]), .y_i(s_y[j]), .y2_i(s_y2[j]),
			.rad_q(s_rad[j+1]), .r_q(s_r[j+1]), .y_q(s_y[j+1]), .y2_q(s_y2[j+1])
		);
	end

	// denominators of both results
	rdcr_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk(clk), .en(en),
		.a_i(v_y[ROOT_W]), .b_i(s_y[ROOT_W]), .p_i(pk_q),
		.vdiv_s6(vdiv_s6), .sdiv_s6(sdiv_s6), .flags_s6(flags_s6)
	);

	// reciprocal rows; quotient too large when the top part reaches the divisor
	assign vr_rem[0]  = V_REM0;
	assign vr_quo[0]  = '0;
	assign vr_side[0] = {flags_s6.val_big | (vdiv_s6 <= V_REM0), vdiv_s6};
	assign sr_rem[0]  = S_REM0;
	assign sr_quo[0]  = '0;
	assign sr_side[0] = {flags_s6.slope_zero | (sdiv_s6 <= S_REM0), sdiv_s6};

	for (genvar k = 0; k < OUT_W; k++) begin : g_recip
		rdcr_div_cell #(.REM_W(VW), .QUO_W(OUT_W), .SIDE_W(VW+1)) u_vcell (
			.clk(clk), .en(en),
			.rem_i(vr_rem[k]), .dvs_i(vr_side[k][VW-1:0]), .quo_i(vr_quo[k]),
			.bit_i(V_NUM_LO[OUT_W-1-k]), .side_i(vr_side[k]),
			.rem_q(vr_rem[k+1]), .quo_q(vr_quo[k+1]), .side_q(vr_side[k+1])
		);
		rdcr_div_cell #(.REM_W(DDW), .QUO_W(OUT_W), .SIDE_W(DDW+1)) u_scell (
			.clk(clk), .en(en),
			.rem_i(sr_rem[k]), .dvs_i(sr_side[k][DDW-1:0]), .quo_i(sr_quo[k]),
			.bit_i(S_NUM_LO[OUT_W-1-k]), .side_i(sr_side[k]),
			.rem_q(sr_rem[k+1]), .quo_q(sr_quo[k+1]), .side_q(sr_side[k+1])
		);
	end

	// saturate and register the result
	always_comb begin
		vbad = (pk_q == '0) | vr_side[OUT_W][VW];
		sbad = (pk_q == '0) | sr_side[OUT_W][DDW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= vbad ? '1 : vr_quo[OUT_W];
			slope_q <= sbad ? '1 : sr_quo[OUT_W];
			sat_q   <= vbad | sbad;
		end
	end

	assign radial_value = value_q;
	assign radial_slope = slope_q;
	assign saturated    = sat_q;

endmodule

// File: tb/tb_radial_distribution_cube_root.sv
`timescale 1ns / 1ps

module tb_radial_distribution_cube_root;
	import rdcr_pkg::*;

	localparam int F = FRAC_BITS_DEF;
	localparam int PIPE_LAT = 4 * F + 62;
	localparam int N_RANDOM = 1750;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [OUT_W-1:0] SAT_MAX = 32'hFFFFFFFF;
	localparam logic [CFG_W-1:0] EPS_Q = 17'd66;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic [OUT_W-1:0] slope;
		logic             sat;
	} radial_res_t;

	// directed row: alpha plus an optional typed-in expectation
	typedef struct {
		logic [CFG_W-1:0] alpha;
		bit               typed;
		radial_res_t      res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [CFG_W-1:0] alpha;
	logic out_valid;
	logic out_stall;
	logic [OUT_W-1:0] radial_value;
	logic [OUT_W-1:0] radial_slope;
	logic saturated;

	logic [CFG_W-1:0] fric_lim;
	logic [CFG_W-1:0] pack_lim;
	radial_res_t expected_q[$];
	int errors;
	longint cycles;
	bit hold_off;
	bit typed_pending;
	radial_res_t typed_res;

	radial_distribution_cube_root DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .alpha(alpha),
		.out_valid(out_valid), .out_stall(out_stall),
		.radial_value(radial_value), .radial_slope(radial_slope),
		.saturated(saturated)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// largest a with a^3 * p <= c * 2^(3F)
	function automatic logic [63:0] cube_root_q(logic [CFG_W-1:0] c, logic [CFG_W-1:0] p);
		logic [127:0] rhs;
		logic [127:0] t3;
		logic [63:0] a;
		logic [63:0] t;
		rhs = 128'(c) << (3 * F);
		a = 0;
		for (int b = F + 5; b >= 0; b--) begin
			t = a | (64'd1 << b);
			t3 = 128'(t) * 128'(t) * 128'(t) * 128'(p);
			if (t3 <= rhs)
				a = t;
		end
		return a;
	endfunction

	// g0 and its slope for one volume fraction
	function automatic radial_res_t radial_predict(logic [CFG_W-1:0] a_in);
		radial_res_t r;
		logic [CFG_W-1:0] c;
		logic [CFG_W-1:0] c2;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] prod;
		logic [63:0] sq;
		logic [63:0] diff;
		logic [63:0] dq;
		logic [63:0] v;
		logic [127:0] n;
		r.value = SAT_MAX;
		r.slope = SAT_MAX;
		r.sat = 1'b0;
		if (pack_lim == 0) begin
			r.sat = 1'b1;
			return r;
		end
		c = (a_in < fric_lim) ? a_in : fric_lim;
		a = cube_root_q(c, pack_lim);
		if (a >= (64'd1 << F)) begin
			r.sat = 1'b1;
		end else begin
			v = (64'd1 << (2 * F)) / ((64'd1 << F) - a);
			if (v > 64'(SAT_MAX))
				r.sat = 1'b1;
			else
				r.value = v[OUT_W-1:0];
		end
		c2 = (a_in > EPS_Q) ? a_in : EPS_Q;
		if (c2 > fric_lim)
			c2 = fric_lim;
		b = cube_root_q(c2, pack_lim);
		prod = b << F;
		sq = b * b;
		diff = (prod >= sq) ? prod - sq : sq - prod;
		dq = diff >> F;
		if (dq == 0) begin
			r.sat = 1'b1;
		end else begin
			// successive floors equal one floor of the product
			n = (128'd1 << (4 * F)) / (128'(3 * pack_lim) * 128'(dq) * 128'(dq));
			if (n > 128'(SAT_MAX))
				r.sat = 1'b1;
			else
				r.slope = n[OUT_W-1:0];
		end
		return r;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int mode;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				for (int i = 0; i < 3 * PIPE_LAT; i++)
					@(posedge clk);
				hold_off = 1'b0;
				out_stall <= 1'b0;
			end else begin
				mode = int'((cycles / 400) % 3);
				if (mode == 0)
					out_stall <= 1'b0;
				else if (mode == 1)
					out_stall <= ($urandom_range(0, 3) == 0);
				else
					out_stall <= ($urandom_range(0, 1) == 0);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		radial_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected request out: value %h slope %h sat %b",
					$time, radial_value, radial_slope, saturated);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (radial_value !== e.value) begin
					$display("%0t radial_value expected %h actual %h", $time, e.value, radial_value);
					errors++;
				end
				if (radial_slope !== e.slope) begin
					$display("%0t radial_slope expected %h actual %h", $time, e.slope, radial_slope);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t saturated expected %b actual %b", $time, e.sat, saturated);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRICTION)
			fric_lim = data;
		else
			pack_lim = data;
	endtask

	// wait for every expected result, then let the pipeline drain
	task automatic drain_pipe();
		longint t0;
		t0 = cycles;
		while (expected_q.size() != 0 && cycles - t0 < 200000)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	// offer one request, hold until taken, record its expectation
	task automatic send_alpha(logic [CFG_W-1:0] a_in, bit typed, radial_res_t tres);
		radial_res_t e;
		in_valid <= 1'b1;
		alpha <= a_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		e = radial_predict(a_in);
		if (typed && (e.value !== tres.value || e.slope !== tres.slope || e.sat !== tres.sat)) begin
			$display("%0t table row alpha %h: expected %h %h %b predicted %h %h %b",
				$time, a_in, tres.value, tres.slope, tres.sat, e.value, e.slope, e.sat);
			errors++;
		end
		expected_q.push_back(typed ? tres : e);
	endtask

	// sender in bursts with random gaps
	task automatic send_burst(logic [CFG_W-1:0] a_in, inout int burst);
		radial_res_t none;
		none = '{0, 0, 0};
		if (burst == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst = $urandom_range(1, 30);
		end
		send_alpha(a_in, 1'b0, none);
		burst--;
	endtask

	function automatic logic [CFG_W-1:0] rand_alpha();
		case ($urandom_range(0, 5))
			0: return CFG_W'($urandom_range(0, 131071));
			1: return CFG_W'($urandom_range(0, 200));
			2: return CFG_W'($urandom_range(60000, 65536));
			3: return CFG_W'(fric_lim + CFG_W'($urandom_range(0, 4)) - CFG_W'(2));
			default: return CFG_W'($urandom_range(0, 65536));
		endcase
	endfunction

	initial begin
		stim_row_t rows[$];
		radial_res_t none;
		logic [CFG_W-1:0] fl_set[8];
		logic [CFG_W-1:0] pl_set[8];
		int burst;
		none = '{0, 0, 0};
		errors = 0;
		cycles = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_FRICTION;
		cfg_data = '0;
		in_valid = 1'b0;
		alpha = '0;
		fric_lim = FRICTION_RST;
		pack_lim = PACKING_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset settings
		rows.push_back('{17'd0, 1'b0, none});
		rows.push_back('{17'd1, 1'b0, none});
		rows.push_back('{17'd66, 1'b0, none});
		rows.push_back('{17'd67, 1'b0, none});
		rows.push_back('{17'd32767, 1'b0, none});
		rows.push_back('{17'd32768, 1'b0, none});
		rows.push_back('{17'd65535, 1'b0, none});
		rows.push_back('{17'd65536, 1'b0, none});
		rows.push_back('{17'h1FFFF, 1'b0, none});
		rows.push_back('{17'h0AAAA, 1'b0, none});
		rows.push_back('{17'h15555, 1'b0, none});
		foreach (rows[i])
			send_alpha(rows[i].alpha, rows[i].typed, rows[i].res);
		in_valid <= 1'b0;
		drain_pipe();

		// zero packing limit: everything saturates
		write_reg(REG_PACKING, 17'd0);
		send_alpha(17'd0, 1'b1, '{SAT_MAX, SAT_MAX, 1'b1});
		send_alpha(17'h1FFFF, 1'b1, '{SAT_MAX, SAT_MAX, 1'b1});
		in_valid <= 1'b0;
		drain_pipe();

		// cap equal to packing: value denominator hits zero
		write_reg(REG_PACKING, 17'd65536);
		write_reg(REG_FRICTION, 17'h1FFFF);
		send_alpha(17'd65536, 1'b1, '{SAT_MAX, SAT_MAX, 1'b1});
		send_alpha(17'h1FFFF, 1'b0, none);
		send_alpha(17'd30000, 1'b0, none);
		// friction limit below the slope clamp
		in_valid <= 1'b0;
		drain_pipe();
		write_reg(REG_FRICTION, 17'd10);
		send_alpha(17'd0, 1'b0, none);
		send_alpha(17'd500, 1'b0, none);
		in_valid <= 1'b0;
		drain_pipe();
		write_reg(REG_FRICTION, 17'd0);
		send_alpha(17'd0, 1'b0, none);
		send_alpha(17'd1234, 1'b0, none);
		in_valid <= 1'b0;
		drain_pipe();

		// random phases over several settings, extremes included
		fl_set = '{17'd32768, 17'd0, 17'd65536, 17'h1FFFF, 17'd66, 17'd50000, 17'd40000, 17'd20000};
		pl_set = '{17'd41288, 17'd1, 17'd65536, 17'h1FFFF, 17'd41288, 17'd52000, 17'd30000, 17'd0};
		burst = 0;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_FRICTION, fl_set[ph]);
			write_reg(REG_PACKING, pl_set[ph]);
			if (ph == 1)
				hold_off = 1'b1;
			for (int i = 0; i < N_RANDOM / 8; i++)
				send_burst(rand_alpha(), burst);
			in_valid <= 1'b0;
			drain_pipe();
		end

		if (expected_q.size() != 0) begin
			$display("%0t %0d results never arrived", $time, expected_q.size());
			errors++;
		end
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
